### hdl/motor_command_frame_decoder_macros.svh
// assertion helpers shared by the frame decoder
`ifndef MOTOR_COMMAND_FRAME_DECODER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_DECODER_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define MCFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define MCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mcfd_pkg.sv
package mcfd_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'd127;
  localparam logic [7:0] CENTER_OFFSET = 8'd50;
  // offsets above this magnitude always saturate the duty
  localparam logic [7:0] MAG_LIMIT     = 8'd50;
  localparam logic [7:0] DUTY_MAX      = 8'd255;

  // duty = mag * 255 / 50 = (mag * 51 * 52429) >> 19, exact for mag up to 50
  localparam int unsigned  DUTY_SHIFT  = 19;
  localparam int unsigned  PROD_W      = 28;
  localparam logic [21:0]  DUTY_RECIP  = 22'd2673879;

  localparam logic [3:0]   INVERT_RESET = 4'hC;

  localparam int unsigned  HEADLIGHT_BIT = 0;
  localparam int unsigned  SLEEP_BIT     = 1;

  typedef enum logic {
    KIND_DRIVE = 1'b0,
    KIND_FLAGS = 1'b1
  } update_kind_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MOT0  = 6'b000010,
    ST_MOT1  = 6'b000100,
    ST_MOT2  = 6'b001000,
    ST_MOT3  = 6'b010000,
    ST_FLAGS = 6'b100000
  } frame_state_t;

endpackage

### hdl/motor_command_frame_decoder.sv
// Frame decoder for the drive link: takes one received byte per request, waits
// for the header byte 127, then turns the next four bytes into duty/direction
// updates for motors 0..3 and the fifth into a headlight/sleep flags update.
// A new byte can be accepted every clock cycle while in_stall is low; each
// accepted byte is held in the input register and then its result in the
// result register, and the header byte or bytes dropped while idle give no
// result. Back-pressure on the result side reaches in_stall only once both
// the input register and the result register hold a request. The invert mask
// (reset 4'hC) is written through the cfg port, which is always ready.
module motor_command_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_update_kind,
  output logic [1:0] out_motor_index,
  output logic [7:0] out_duty,
  output logic       out_direction_level,
  output logic       out_headlight_on,
  output logic       out_motor_sleep,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_direction_invert_mask
);

  mcfd_pkg::frame_state_t state_r, state_nxt;
  logic [3:0]             invert_mask_r;

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;

  logic                   out_valid_r;
  logic                   kind_r;
  logic [1:0]             motor_idx_r;
  logic [7:0]             duty_r;
  logic                   dir_r;
  logic                   headlight_r;
  logic                   sleep_r;

  logic                   s2_free;
  logic                   s1_adv;
  logic                   in_accept;

  logic                   res_valid;
  logic                   res_kind;
  logic [1:0]             res_idx;
  logic                   res_drive;
  logic                   neg;
  logic [7:0]             mag;
  logic [mcfd_pkg::PROD_W-1:0] prod;
  logic [7:0]             duty_calc;

  assign cfg_ready = 1'b1;

  assign s2_free   = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_stall  = s1_valid_r && !s2_free;
  assign in_accept = in_valid && !in_stall;

  // offset from center and its magnitude
  assign neg = (s1_byte_r < mcfd_pkg::CENTER_OFFSET);
  assign mag = neg ? (mcfd_pkg::CENTER_OFFSET - s1_byte_r)
                   : (s1_byte_r - mcfd_pkg::CENTER_OFFSET);
  assign prod = mcfd_pkg::PROD_W'(mag[5:0]) * mcfd_pkg::PROD_W'(mcfd_pkg::DUTY_RECIP);
  assign duty_calc = (mag > mcfd_pkg::MAG_LIMIT) ? mcfd_pkg::DUTY_MAX
                   : prod[mcfd_pkg::DUTY_SHIFT+7:mcfd_pkg::DUTY_SHIFT];

  always_comb begin
    state_nxt = state_r;
    res_valid = 1'b0;
    res_kind  = mcfd_pkg::KIND_DRIVE;
    res_idx   = 2'd0;
    res_drive = 1'b0;
    unique case (state_r)
      mcfd_pkg::ST_IDLE: begin
        state_nxt = (s1_byte_r == mcfd_pkg::HEADER_BYTE) ? mcfd_pkg::ST_MOT0
                                                         : mcfd_pkg::ST_IDLE;
      end
      mcfd_pkg::ST_MOT0: begin
        state_nxt = mcfd_pkg::ST_MOT1;
        res_valid = 1'b1;
        res_drive = 1'b1;
        res_idx   = 2'd0;
      end
      mcfd_pkg::ST_MOT1: begin
        state_nxt = mcfd_pkg::ST_MOT2;
        res_valid = 1'b1;
        res_drive = 1'b1;
        res_idx   = 2'd1;
      end
      mcfd_pkg::ST_MOT2: begin
        state_nxt = mcfd_pkg::ST_MOT3;
        res_valid = 1'b1;
        res_drive = 1'b1;
        res_idx   = 2'd2;
      end
      mcfd_pkg::ST_MOT3: begin
        state_nxt = mcfd_pkg::ST_FLAGS;
        res_valid = 1'b1;
        res_drive = 1'b1;
        res_idx   = 2'd3;
      end
      mcfd_pkg::ST_FLAGS: begin
        state_nxt = mcfd_pkg::ST_IDLE;
        res_valid = 1'b1;
        res_kind  = mcfd_pkg::KIND_FLAGS;
      end
      default: begin
        state_nxt = mcfd_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mcfd_pkg::ST_IDLE;
      invert_mask_r <= mcfd_pkg::INVERT_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        invert_mask_r <= cfg_direction_invert_mask;
      end
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r && res_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_adv) begin
      kind_r      <= res_kind;
      motor_idx_r <= res_idx;
      duty_r      <= res_drive ? duty_calc : 8'd0;
      dir_r       <= res_drive && (neg ^ invert_mask_r[res_idx]);
      headlight_r <= !res_drive && s1_byte_r[mcfd_pkg::HEADLIGHT_BIT];
      sleep_r     <= !res_drive && s1_byte_r[mcfd_pkg::SLEEP_BIT];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_update_kind     = kind_r;
  assign out_motor_index     = motor_idx_r;
  assign out_duty            = duty_r;
  assign out_direction_level = dir_r;
  assign out_headlight_on    = headlight_r;
  assign out_motor_sleep     = sleep_r;

`include "motor_command_frame_decoder_macros.svh"

  `MCFD_ASSERT_NOW(a_flags_clean, out_valid_r && (kind_r == mcfd_pkg::KIND_FLAGS), (duty_r == 8'd0) && (motor_idx_r == 2'd0) && !dir_r, "flags result carries drive fields")
  `MCFD_ASSERT_NOW(a_drive_clean, out_valid_r && (kind_r == mcfd_pkg::KIND_DRIVE), !headlight_r && !sleep_r, "drive result carries flags")
  `MCFD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r, "input stalled with room in the pipe")
  `MCFD_ASSERT_NEXT(a_header_starts, s1_adv && (state_r == mcfd_pkg::ST_IDLE) && (s1_byte_r == mcfd_pkg::HEADER_BYTE), state_r == mcfd_pkg::ST_MOT0, "header did not start a frame")
  `MCFD_ASSERT_NEXT(a_flags_ends, s1_adv && (state_r == mcfd_pkg::ST_FLAGS), (state_r == mcfd_pkg::ST_IDLE) && out_valid_r && (kind_r == mcfd_pkg::KIND_FLAGS), "flags byte did not close the frame")

endmodule
